// ===== hdl/row_column_union_find_macros.svh =====
// assertion macros for the row/column union-find stone counter
// used by the checker; needs clk and rst in the scope that uses them
`ifndef ROW_COLUMN_UNION_FIND_MACROS_SVH
`define ROW_COLUMN_UNION_FIND_MACROS_SVH

// same-cycle implication
`define RCUF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rcuf check failed");

// next-cycle implication
`define RCUF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rcuf check failed");

`endif

// ===== hdl/rcuf_pkg.sv =====
// types and constants for the row/column union-find stone counter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rcuf_pkg;

  localparam int COORD_W = 8;
  localparam int COUNT_W = 16;
  localparam int EPOCH_W = 8;

  typedef struct packed {
    logic               first;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] moves;
    logic               saturated;
  } out_t;

  // counter events from the forest walker
  typedef struct packed {
    logic clear;
    logic stone;
    logic comp_inc;
    logic comp_dec;
    logic finish;
  } cnt_ev_t;

endpackage

`default_nettype wire

// ===== hdl/rcuf_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module rcuf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/rcuf_walker.sv =====
// forest walker: root search, path compression, linking and epoch sweep
// depends on rcuf_pkg; drives the parent ram in the top level
`timescale 1ns / 1ps
`default_nettype none

module rcuf_walker #(
  parameter int COORD_RANGE = 256,
  localparam int NODES = 2 * COORD_RANGE,
  localparam int NODE_W = $clog2(NODES),
  localparam int MEM_W = rcuf_pkg::EPOCH_W + NODE_W
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                accept,
  input  wire logic                first,
  input  wire logic [NODE_W-1:0]   row_node,
  input  wire logic [NODE_W-1:0]   col_node,
  output      logic                busy,
  output      rcuf_pkg::cnt_ev_t   ev,
  output      logic                mem_we,
  output      logic [NODE_W-1:0]   mem_waddr,
  output      logic [MEM_W-1:0]    mem_wdata,
  output      logic [NODE_W-1:0]   mem_raddr,
  input  wire logic [MEM_W-1:0]    mem_rdata
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_BEGIN = 3'd2;
  localparam logic [2:0] S_FIRST = 3'd3;
  localparam logic [2:0] S_WALK  = 3'd4;
  localparam logic [2:0] S_COMP  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODES - 1);
  localparam logic [rcuf_pkg::EPOCH_W-1:0] EPOCH_ONE = rcuf_pkg::EPOCH_W'(1);

  logic [2:0]                   state, state_next;
  logic [NODE_W-1:0]            clr_addr, clr_addr_next;
  logic                         resume, resume_next;
  logic [rcuf_pkg::EPOCH_W-1:0] epoch, epoch_next;
  logic [NODE_W-1:0]            row_q, row_q_next;
  logic [NODE_W-1:0]            col_q, col_q_next;
  logic                         sel, sel_next;
  logic [NODE_W-1:0]            start_q, start_q_next;
  logic [NODE_W-1:0]            cur, cur_next;
  logic [NODE_W-1:0]            top, top_next;
  logic [NODE_W-1:0]            ra, ra_next;

  logic [rcuf_pkg::EPOCH_W-1:0] rd_tag;
  logic [NODE_W-1:0]            rd_par;
  logic                         found;
  logic [NODE_W-1:0]            root;

  assign rd_tag = mem_rdata[MEM_W-1 -: rcuf_pkg::EPOCH_W];
  assign rd_par = mem_rdata[NODE_W-1:0];
  assign busy   = (state != S_IDLE);

  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    resume_next   = resume;
    epoch_next    = epoch;
    row_q_next    = row_q;
    col_q_next    = col_q;
    sel_next      = sel;
    start_q_next  = start_q;
    cur_next      = cur;
    top_next      = top;
    ra_next       = ra;
    mem_we        = 1'b0;
    mem_waddr     = cur;
    mem_wdata     = {epoch, top};
    mem_raddr     = cur;
    ev            = '0;
    found         = 1'b0;
    root          = cur;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          row_q_next = row_node;
          col_q_next = col_node;
          ev.clear   = first;
          if (first && (epoch == '1)) begin
            state_next    = S_CLEAR;
            clr_addr_next = '0;
            resume_next   = 1'b1;
          end else begin
            if (first) begin
              epoch_next = epoch + EPOCH_ONE;
            end
            state_next = S_BEGIN;
          end
        end
      end
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
        if (clr_addr == LAST_NODE) begin
          epoch_next  = EPOCH_ONE;
          resume_next = 1'b0;
          state_next  = resume ? S_BEGIN : S_IDLE;
        end else begin
          clr_addr_next = clr_addr + NODE_W'(1);
        end
      end
      S_BEGIN: begin
        ev.stone     = 1'b1;
        sel_next     = 1'b0;
        start_q_next = row_q;
        cur_next     = row_q;
        mem_raddr    = row_q;
        state_next   = S_FIRST;
      end
      S_FIRST: begin
        if (rd_tag != epoch) begin
          // new node becomes its own root
          mem_we      = 1'b1;
          mem_waddr   = start_q;
          mem_wdata   = {epoch, start_q};
          ev.comp_inc = 1'b1;
          found       = 1'b1;
          root        = start_q;
        end else if (rd_par == cur) begin
          found = 1'b1;
          root  = cur;
        end else begin
          cur_next   = rd_par;
          mem_raddr  = rd_par;
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (rd_par == cur) begin
          top_next   = cur;
          cur_next   = start_q;
          mem_raddr  = start_q;
          state_next = S_COMP;
        end else begin
          cur_next  = rd_par;
          mem_raddr = rd_par;
        end
      end
      S_COMP: begin
        if (cur == top) begin
          found = 1'b1;
          root  = top;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = cur;
          mem_wdata = {epoch, top};
          cur_next  = rd_par;
          mem_raddr = rd_par;
        end
      end
      S_FIN: begin
        if (ra != top) begin
          mem_we      = 1'b1;
          mem_waddr   = ra;
          mem_wdata   = {epoch, top};
          ev.comp_dec = 1'b1;
        end
        state_next = S_OUT;
      end
      S_OUT: begin
        ev.finish  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (found) begin
      if (!sel) begin
        ra_next      = root;
        sel_next     = 1'b1;
        start_q_next = col_q;
        cur_next     = col_q;
        mem_raddr    = col_q;
        state_next   = S_FIRST;
      end else begin
        top_next   = root;
        state_next = S_FIN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      resume   <= 1'b0;
      epoch    <= EPOCH_ONE;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      resume   <= resume_next;
      epoch    <= epoch_next;
    end
    row_q   <= row_q_next;
    col_q   <= col_q_next;
    sel     <= sel_next;
    start_q <= start_q_next;
    cur     <= cur_next;
    top     <= top_next;
    ra      <= ra_next;
  end

endmodule

`default_nettype wire

// ===== hdl/row_column_union_find.sv =====
// channel   dir  handshake            payload
// stone     in   start & !busy        rcuf_pkg::in_t  (first, row, col)
// result    out  done, one cycle      rcuf_pkg::out_t (moves, saturated)
//
// a stone whose nodes are both new or roots goes from transfer through the begin state, a check
// of each node, the link state and the output state to the done register; a search from a node
// below its root adds reads up the path, rewrites of the path to the root and one final check
// the next stone can transfer in the cycle that shows the result
// after reset, and at every 255th clearing stone, a tag sweep over all 2*COORD_RANGE nodes holds busy high
// done pulses for one cycle and the receiver cannot hold it off
//
// top level: coordinate wrap, stone and component counters, result register
// depends on rcuf_pkg, rcuf_ram, rcuf_walker
`timescale 1ns / 1ps
`default_nettype none

module row_column_union_find #(
  parameter int COORD_RANGE = 256
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output      logic           busy,
  input  wire rcuf_pkg::in_t  stone,
  output      logic           done,
  output      rcuf_pkg::out_t result
);

  localparam int NODES = 2 * COORD_RANGE;
  localparam int NODE_W = $clog2(NODES);
  localparam int MEM_W = rcuf_pkg::EPOCH_W + NODE_W;
  localparam logic [NODE_W-1:0] RANGE_N = NODE_W'(COORD_RANGE);
  localparam logic [rcuf_pkg::COUNT_W-1:0] COUNT_ONE = rcuf_pkg::COUNT_W'(1);

  function automatic logic [NODE_W-1:0] wrap_coord(input logic [rcuf_pkg::COORD_W-1:0] v);
    logic [NODE_W-1:0] rem;
    rem = '0;
    for (int i = rcuf_pkg::COORD_W - 1; i >= 0; i--) begin
      rem = {rem[NODE_W-2:0], v[i]};
      if (rem >= RANGE_N) begin
        rem = rem - RANGE_N;
      end
    end
    return rem;
  endfunction

  logic                            accept;
  logic [NODE_W-1:0]               row_node;
  logic [NODE_W-1:0]               col_node;
  rcuf_pkg::cnt_ev_t               ev;
  logic                            mem_we;
  logic [NODE_W-1:0]               mem_waddr;
  logic [MEM_W-1:0]                mem_wdata;
  logic [NODE_W-1:0]               mem_raddr;
  logic [MEM_W-1:0]                mem_rdata;
  logic [rcuf_pkg::COUNT_W-1:0]    stones;
  logic [rcuf_pkg::COUNT_W-1:0]    comps;

  assign accept   = start && !busy;
  assign row_node = wrap_coord(stone.row);
  assign col_node = wrap_coord(stone.col) + RANGE_N;

  rcuf_walker #(
    .COORD_RANGE(COORD_RANGE)
  ) u_walker (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .first     (stone.first),
    .row_node  (row_node),
    .col_node  (col_node),
    .busy      (busy),
    .ev        (ev),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  rcuf_ram #(
    .WIDTH(MEM_W),
    .DEPTH(NODES)
  ) u_parent (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stones <= '0;
      comps  <= '0;
      done   <= 1'b0;
    end else begin
      done <= ev.finish;
      if (ev.clear) begin
        stones <= '0;
        comps  <= '0;
      end else begin
        if (ev.stone && (stones != '1)) begin
          stones <= stones + COUNT_ONE;
        end
        if (ev.comp_inc) begin
          comps <= comps + COUNT_ONE;
        end else if (ev.comp_dec && (comps != '0)) begin
          comps <= comps - COUNT_ONE;
        end
      end
    end
    if (ev.finish) begin
      result.moves     <= (comps > stones) ? '0 : stones - comps;
      result.saturated <= (stones == '1);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rcuf_check.sv =====
// port-level checker for the row/column union-find stone counter, bound to the top
// depends on rcuf_pkg and row_column_union_find_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "row_column_union_find_macros.svh"

module rcuf_check (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           start,
  input wire logic           busy,
  input wire logic           done,
  input wire rcuf_pkg::out_t result
);

  // a transfer in makes the block busy
  `RCUF_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // results only come out of work in progress
  `RCUF_ASSERT_NEXT(a_idle_no_done, !busy, !done)
  // one strobe per stone
  `RCUF_ASSERT_NEXT(a_done_single, done, !done)
  // a full stone counter always leaves removable stones
  `RCUF_ASSERT_NOW(a_sat_moves, done && result.saturated, result.moves != '0)
  // a result is shown only while the block is not busy or start was already high
  `RCUF_ASSERT_NOW(a_done_free, done, !busy || $past(start))

endmodule

bind row_column_union_find rcuf_check u_check (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire

// ===== tb/row_column_union_find_tb.sv =====
// testbench for row_column_union_find: stones go in through the start/busy command port,
// a forest model with path compression predicts each result and a checker compares it
// depends on rcuf_pkg and row_column_union_find
`timescale 1ns / 1ps

module row_column_union_find_tb;

  localparam int COORD_RANGE = 256;
  localparam int NODES = 2 * COORD_RANGE;
  localparam int unsigned STONE_MAX = 65535;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned TAIL_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  rcuf_pkg::in_t stone = '0;
  logic done;
  rcuf_pkg::out_t result;

  row_column_union_find #(.COORD_RANGE(COORD_RANGE)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .stone(stone),
    .done(done),
    .result(result)
  );

  always #5 clk = ~clk;

  // forest model
  logic [8:0] forest_parent [NODES];
  bit node_seen [NODES];
  int unsigned comp_total = 0;
  int unsigned stone_total = 0;

  rcuf_pkg::out_t pending_results[$];
  rcuf_pkg::out_t due_result;
  int unsigned fail_count = 0;
  int unsigned stones_sent = 0;
  int unsigned clears_sent = 0;
  int unsigned results_seen = 0;
  int unsigned stall_cycles = 0;
  bit idle_on = 1'b1;

  function automatic void clear_forest();
    for (int n = 0; n < NODES; n++) node_seen[n] = 1'b0;
    comp_total = 0;
    stone_total = 0;
  endfunction

  function automatic int unsigned forest_root(int unsigned node);
    int unsigned top;
    int unsigned walk;
    int unsigned nxt;
    if (!node_seen[node]) begin
      node_seen[node] = 1'b1;
      forest_parent[node] = 9'(node);
      comp_total++;
      return node;
    end
    top = node;
    while (forest_parent[top] != top) top = forest_parent[top];
    walk = node;
    while (walk != top) begin
      nxt = forest_parent[walk];
      forest_parent[walk] = 9'(top);
      walk = nxt;
    end
    return top;
  endfunction

  function automatic rcuf_pkg::out_t place_stone(rcuf_pkg::in_t s);
    int unsigned ra;
    int unsigned rb;
    int unsigned moves;
    rcuf_pkg::out_t r;
    if (s.first) clear_forest();
    if (stone_total < STONE_MAX) stone_total++;
    ra = forest_root(s.row % COORD_RANGE);
    rb = forest_root(COORD_RANGE + s.col % COORD_RANGE);
    if (ra != rb) begin
      forest_parent[ra] = 9'(rb);
      if (comp_total > 0) comp_total--;
    end
    moves = (comp_total > stone_total) ? 0 : stone_total - comp_total;
    r.moves = moves[15:0];
    r.saturated = (stone_total >= STONE_MAX);
    return r;
  endfunction

  function automatic rcuf_pkg::in_t mk(bit f, logic [7:0] r, logic [7:0] c);
    rcuf_pkg::in_t s;
    s.first = f;
    s.row = r;
    s.col = c;
    return s;
  endfunction

  // one stone transfer, with an optional idle burst in front
  task automatic send_stone(input rcuf_pkg::in_t s);
    int unsigned gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    stone <= s;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(place_stone(s));
    stones_sent++;
    if (s.first) clears_sent++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_corners();
    idle_on = 1'b1;
    send_stone(mk(1'b0, 8'd0, 8'd0));
    send_stone(mk(1'b0, 8'd0, 8'd0));
    send_stone(mk(1'b0, 8'd255, 8'd255));
    send_stone(mk(1'b0, 8'd0, 8'd255));
    send_stone(mk(1'b0, 8'd255, 8'd0));
    send_stone(mk(1'b0, 8'hAA, 8'h55));
    send_stone(mk(1'b0, 8'h55, 8'hAA));
    // long column chain, then a walk through it
    for (int k = 1; k <= 6; k++) send_stone(mk(1'b0, 8'd1, 8'(k)));
    send_stone(mk(1'b0, 8'd9, 8'd1));
    send_stone(mk(1'b0, 8'd1, 8'd1));
    send_stone(mk(1'b1, 8'd255, 8'd255));
    send_stone(mk(1'b1, 8'd0, 8'd0));
    send_stone(mk(1'b0, 8'd128, 8'd127));
  endtask

  task automatic test_drain();
    idle_on = 1'b1;
    for (int k = 0; k < 5; k++) send_stone(mk(k == 0, 8'($urandom), 8'($urandom)));
    wait_drained();
    for (int k = 0; k < 5; k++) send_stone(mk(1'b0, 8'($urandom), 8'($urandom)));
  endtask

  task automatic test_short_sets(int unsigned sets);
    int unsigned len;
    idle_on = 1'b1;
    for (int g = 0; g < sets; g++) begin
      len = $urandom_range(1, 3);
      for (int k = 0; k < len; k++) send_stone(mk(k == 0, 8'($urandom), 8'($urandom)));
    end
  endtask

  task automatic test_games(int unsigned sets, bit allow_idle);
    int unsigned len;
    int unsigned span_r;
    int unsigned span_c;
    logic [7:0] base_r;
    logic [7:0] base_c;
    rcuf_pkg::in_t s;
    for (int g = 0; g < sets; g++) begin
      idle_on = allow_idle && ($urandom_range(0, 3) != 0);
      len = $urandom_range(10, 40);
      span_r = $urandom_range(2, 24);
      span_c = $urandom_range(2, 24);
      base_r = 8'($urandom);
      base_c = 8'($urandom);
      for (int k = 0; k < len; k++) begin
        s.first = (k == 0);
        s.row = base_r + 8'($urandom_range(0, span_r - 1));
        s.col = base_c + 8'($urandom_range(0, span_c - 1));
        // broken sets: missing opener clear or a stray clear
        if ($urandom_range(0, 29) == 0) s.first = ~s.first;
        send_stone(s);
      end
    end
  endtask

  task automatic test_noise(int unsigned count);
    idle_on = 1'b1;
    for (int k = 0; k < count; k++)
      send_stone(mk($urandom_range(0, 15) == 0, 8'($urandom), 8'($urandom)));
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with no stone outstanding: moves %0d saturated %0d",
               result.moves, result.saturated);
        fail_count++;
      end else begin
        due_result = pending_results.pop_front();
        if (result.moves !== due_result.moves) begin
          $error("moves: expected %0d, actual %0d", due_result.moves, result.moves);
          fail_count++;
        end
        if (result.saturated !== due_result.saturated) begin
          $error("saturated: expected %0d, actual %0d", due_result.saturated,
                 result.saturated);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (start && busy === 1'b0) || done === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    clear_forest();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_corners();
    test_drain();
    test_short_sets(300);
    test_games(40, 1'b1);
    test_noise(150);
    test_games(4, 1'b0);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d stones (%0d clearing), %0d results checked", stones_sent,
             clears_sent, results_seen);
    $display("included corner coordinates, long chains, a full drain and back-to-back clears");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
